// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by epoch_seconds_to_calendar_date
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define ES2CD_ASSERT_SAME(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define ES2CD_ASSERT_NEXT(label, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/es2cd_pkg.sv =====
// shared constants, types and tables for the epoch to calendar converter
package es2cd_pkg;

	// field widths
	localparam int EPOCH_W  = 32;
	localparam int ZONE_W   = 17;
	localparam int YEAR_W   = 12;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;

	// widths of the intermediate values
	localparam int LOCAL_W = EPOCH_W + 1;    // non-negative local time
	localparam int DAYS_W  = 17;             // whole days since epoch
	localparam int SOD_W   = 17;             // seconds of day
	localparam int DOC_W   = 11;             // day within a four-year cycle
	localparam int TOD_W   = 11;             // minutes of day
	localparam int CYC_W   = 7;              // four-year cycle count

	// constants
	localparam int SEC_PER_DAY    = 86400;
	localparam int SEC_PER_HOUR   = 3600;
	localparam int SEC_PER_MIN    = 60;
	localparam int MIN_PER_HOUR   = SEC_PER_HOUR / SEC_PER_MIN;
	localparam int DAYS_PER_CYCLE = 1461;
	localparam int BASE_YEAR      = 1970;
	localparam int ZONE_RESET     = 28800;
	localparam int LEAP_SLOT      = 2;       // 1972 is the third year of each cycle
	localparam int LAST_SLOT      = 3;
	localparam int LAST_MONTH     = 11;

	typedef enum logic [1:0] {
		TOP_IDLE,
		TOP_DAYS,
		TOP_SPLIT,
		TOP_FINISH
	} top_state_t;

	typedef enum logic [1:0] {
		WALK_IDLE,
		WALK_YEAR,
		WALK_MONTH
	} walk_state_t;

	// days in the year at a slot of the four-year cycle
	function automatic logic [8:0] year_len(input logic [1:0] slot);
		year_len = (slot == 2'(LEAP_SLOT)) ? 9'd366 : 9'd365;
	endfunction

	// days in a month, index 0 is january
	function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
		case (idx)
			4'd1:                      month_len = leap ? 5'd29 : 5'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
			default:                   month_len = 5'd31;
		endcase
	endfunction

endpackage

// ===== hw/rtl/epoch_seconds_to_calendar_date.sv =====
// Epoch seconds to local calendar date and time of day.
// Sequence: a 33-step divide by 86400, then, side by side,
// the 28-step time split and the 17-step divide by 1461 followed by the date walk.
// One beat at a time; the next can be taken the cycle after the result is loaded.
// Reset: arst_n clears control state and sets the zone offset to +28800 seconds.
`include "assert_macros.svh"
module epoch_seconds_to_calendar_date import es2cd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wr_en,
	input  logic signed [ZONE_W-1:0]   cfg_wr_data,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic        [EPOCH_W-1:0]  epoch_seconds,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic        [YEAR_W-1:0]   year,
	output logic        [MONTH_W-1:0]  month,
	output logic        [DAY_W-1:0]    day_of_month,
	output logic        [HOUR_W-1:0]   hour,
	output logic        [MINUTE_W-1:0] minute,
	output logic        [SECOND_W-1:0] second_of_minute,
	output logic                       before_epoch
);

	top_state_t          state_q, state_nxt;
	logic [ZONE_W-1:0]   zone_q;
	logic                early_q;
	logic                hms_q, date_q;
	logic                out_valid_q;

	logic                accept, load, out_free;
	logic [LOCAL_W:0]    local_sum;
	logic [LOCAL_W-1:0]  local_t;

	logic                days_done, cyc_done, tod_done, hr_done, walk_done;
	logic [LOCAL_W-1:0]  days_quo;
	logic [SOD_W-1:0]    sod;
	logic [DAYS_W-1:0]   cyc_quo;
	logic [DOC_W-1:0]    doc;
	logic [SOD_W-1:0]    tod_quo;
	logic [SECOND_W-1:0] sec_rem;
	logic [TOD_W-1:0]    hr_quo;
	logic [MINUTE_W-1:0] min_rem;
	logic [YEAR_W-1:0]   year_base, walk_year;
	logic [MONTH_W-1:0]  walk_month;
	logic [DAY_W-1:0]    walk_day;
	logic                out_is_epoch;

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// local time, saturated at the epoch
	always_comb begin
		local_sum = {2'b00, epoch_seconds} + {{(LOCAL_W + 1 - ZONE_W){zone_q[ZONE_W-1]}}, zone_q};
		local_t   = local_sum[LOCAL_W] ? '0 : local_sum[LOCAL_W-1:0];
	end

	// zone offset register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_W'(ZONE_RESET);
		end else if (cfg_wr_en) begin
			zone_q <= cfg_wr_data;
		end
	end

	// seconds to days and seconds of day
	es2cd_sdiv #(.NUM_W(LOCAL_W), .DEN_W(SOD_W), .DIVISOR(SEC_PER_DAY)) u_div_day (
		.clk(clk), .arst_n(arst_n), .start(accept), .num(local_t),
		.done(days_done), .quo(days_quo), .rem(sod)
	);

	// days to four-year cycles and day of cycle
	es2cd_sdiv #(.NUM_W(DAYS_W), .DEN_W(DOC_W), .DIVISOR(DAYS_PER_CYCLE)) u_div_cyc (
		.clk(clk), .arst_n(arst_n), .start(days_done), .num(days_quo[DAYS_W-1:0]),
		.done(cyc_done), .quo(cyc_quo), .rem(doc)
	);

	// seconds of day to minutes of day and seconds
	es2cd_sdiv #(.NUM_W(SOD_W), .DEN_W(SECOND_W), .DIVISOR(SEC_PER_MIN)) u_div_min (
		.clk(clk), .arst_n(arst_n), .start(days_done), .num(sod),
		.done(tod_done), .quo(tod_quo), .rem(sec_rem)
	);

	// minutes of day to hours and minutes
	es2cd_sdiv #(.NUM_W(TOD_W), .DEN_W(MINUTE_W), .DIVISOR(MIN_PER_HOUR)) u_div_hr (
		.clk(clk), .arst_n(arst_n), .start(tod_done), .num(tod_quo[TOD_W-1:0]),
		.done(hr_done), .quo(hr_quo), .rem(min_rem)
	);

	// first year of the cycle
	assign year_base = YEAR_W'(BASE_YEAR) + {{(YEAR_W - CYC_W - 2){1'b0}}, cyc_quo[CYC_W-1:0], 2'b00};

	es2cd_walk u_walk (
		.clk(clk), .arst_n(arst_n), .start(cyc_done), .year_base(year_base), .day_in(doc),
		.done(walk_done), .year(walk_year), .month(walk_month), .day_of_month(walk_day)
	);

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		load      = 1'b0;
		case (state_q)
			TOP_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) state_nxt = TOP_DAYS;
			end
			TOP_DAYS: begin
				if (days_done) state_nxt = TOP_SPLIT;
			end
			TOP_SPLIT: begin
				if (hms_q && date_q) state_nxt = TOP_FINISH;
			end
			TOP_FINISH: begin
				if (out_free) begin
					load      = 1'b1;
					state_nxt = TOP_IDLE;
				end
			end
			default: state_nxt = TOP_IDLE;
		endcase
	end

	// sequencer and completion flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= TOP_IDLE;
			hms_q       <= 1'b0;
			date_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				hms_q  <= 1'b0;
				date_q <= 1'b0;
			end else begin
				if (hr_done) hms_q <= 1'b1;
				if (walk_done) date_q <= 1'b1;
			end
			if (load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// saturation flag of the beat in flight
	always_ff @(posedge clk) begin
		if (accept) early_q <= local_sum[LOCAL_W];
	end

	// output register
	always_ff @(posedge clk) begin
		if (load) begin
			year             <= walk_year;
			month            <= walk_month;
			day_of_month     <= walk_day;
			hour             <= hr_quo[HOUR_W-1:0];
			minute           <= min_rem;
			second_of_minute <= sec_rem;
			before_epoch     <= early_q;
		end
	end

	assign out_valid = out_valid_q;

	// output register holds 1970-01-01 00:00:00
	assign out_is_epoch = (year == YEAR_W'(BASE_YEAR)) && (month == MONTH_W'(1)) &&
		(day_of_month == DAY_W'(1)) && (hour == '0) && (minute == '0) &&
		(second_of_minute == '0);

	`ES2CD_ASSERT_NEXT(a_accept_starts, accept, state_q == TOP_DAYS, "beat taken without starting")
	`ES2CD_ASSERT_SAME(a_walk_in_split, walk_done, state_q == TOP_SPLIT, "date walk out of phase")
	`ES2CD_ASSERT_SAME(a_hms_in_split, hr_done, state_q == TOP_SPLIT, "time split out of phase")
	`ES2CD_ASSERT_SAME(a_saturated, $rose(out_valid_q) && before_epoch, out_is_epoch, "bad saturation")

endmodule

// ===== hw/rtl/es2cd_sdiv.sv =====
// bit-serial restoring divider by a constant, one quotient bit per cycle
module es2cd_sdiv import es2cd_pkg::*; #(
	parameter int NUM_W   = LOCAL_W,
	parameter int DEN_W   = SOD_W,
	parameter int DIVISOR = SEC_PER_DAY
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	output logic             done,
	output logic [NUM_W-1:0] quo,
	output logic [DEN_W-1:0] rem
);

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [NUM_W-1:0] qn_q;

	logic [DEN_W:0]   partial;
	logic [DEN_W+1:0] diff;
	logic             qbit;
	logic [DEN_W-1:0] rem_nxt;

	// one trial subtract per cycle
	always_comb begin
		partial = {rem_q, qn_q[NUM_W-1]};
		diff    = {1'b0, partial} - (DEN_W + 2)'(DIVISOR);
		qbit    = ~diff[DEN_W+1];
		rem_nxt = qbit ? diff[DEN_W-1:0] : partial[DEN_W-1:0];
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// dividend shifts out at the top, quotient bits shift in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			qn_q  <= num;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			qn_q  <= {qn_q[NUM_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = qn_q;
	assign rem  = rem_q;

endmodule

// ===== hw/rtl/es2cd_walk.sv =====
// year and month walk over the day within a four-year cycle
module es2cd_walk import es2cd_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [YEAR_W-1:0]  year_base,
	input  logic [DOC_W-1:0]   day_in,
	output logic               done,
	output logic [YEAR_W-1:0]  year,
	output logic [MONTH_W-1:0] month,
	output logic [DAY_W-1:0]   day_of_month
);

	walk_state_t        state_q, state_nxt;
	logic               done_q, done_nxt;
	logic [YEAR_W-1:0]  year_q;
	logic [DOC_W-1:0]   rem_q;
	logic [3:0]         idx_q;

	logic [DOC_W-1:0]   ylen, mlen;
	logic               year_fits, month_fits, leap;

	// lengths of the current year and month
	always_comb begin
		leap       = (year_q[1:0] == 2'b00);
		ylen       = DOC_W'(year_len(idx_q[1:0]));
		mlen       = DOC_W'(month_len(idx_q, leap));
		year_fits  = (idx_q < 4'(LAST_SLOT)) && (rem_q >= ylen);
		month_fits = (idx_q != 4'(LAST_MONTH)) && (rem_q >= mlen);
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		done_nxt  = 1'b0;
		case (state_q)
			WALK_IDLE: begin
				if (start) state_nxt = WALK_YEAR;
			end
			WALK_YEAR: begin
				if (!year_fits) state_nxt = WALK_MONTH;
			end
			WALK_MONTH: begin
				if (!month_fits) begin
					state_nxt = WALK_IDLE;
					done_nxt  = 1'b1;
				end
			end
			default: state_nxt = WALK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= WALK_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= done_nxt;
		end
	end

	// year, remaining days and slot or month index
	always_ff @(posedge clk) begin
		case (state_q)
			WALK_IDLE: begin
				if (start) begin
					year_q <= year_base;
					rem_q  <= day_in;
					idx_q  <= '0;
				end
			end
			WALK_YEAR: begin
				if (year_fits) begin
					rem_q  <= rem_q - ylen;
					year_q <= year_q + 1'b1;
					idx_q  <= idx_q + 1'b1;
				end else begin
					idx_q <= '0;
				end
			end
			WALK_MONTH: begin
				if (month_fits) begin
					rem_q <= rem_q - mlen;
					idx_q <= idx_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done         = done_q;
	assign year         = year_q;
	assign month        = idx_q + 1'b1;
	assign day_of_month = rem_q[DAY_W-1:0] + 1'b1;

endmodule
